// ----- hdl/csl_pkg.sv -----
package csl_pkg;
  localparam int MaxVertices = 1024;
  localparam int MaxEdges = 4096;
  localparam int VW = $clog2(MaxVertices);
  localparam int EW = $clog2(MaxEdges);
  localparam int VCW = VW + 1;
  localparam int ECW = EW + 1;
  localparam int CfgW = ECW;

  localparam logic [1:0] OpLoad = 2'd0;
  localparam logic [1:0] OpRun = 2'd1;
  localparam logic [1:0] OpRead = 2'd2;

  localparam logic CfgVertexCount = 1'b0;
  localparam logic CfgEdgeCount = 1'b1;

  typedef struct packed {
    logic          assigned;
    logic [VW-1:0] label;
    logic [VW-1:0] colour;
  } vertex_word_t;

  localparam int WordW = $bits(vertex_word_t);

  typedef enum logic [14:0] {
    S_WIPE = 15'b000000000000001,
    S_IDLE = 15'b000000000000010,
    S_CLR = 15'b000000000000100,
    S_CHK = 15'b000000000001000,
    S_INIT = 15'b000000000010000,
    S_INITW = 15'b000000000100000,
    S_FADDR = 15'b000000001000000,
    S_FRD = 15'b000000010000000,
    S_FEX = 15'b000000100000000,
    S_ROOT = 15'b000001000000000,
    S_RROOT = 15'b000010000000000,
    S_BADDR = 15'b000100000000000,
    S_BRD = 15'b001000000000000,
    S_BEX = 15'b010000000000000,
    S_OUT = 15'b100000000000000
  } state_t;
endpackage

// ----- hdl/csl_ram.sv -----
module csl_ram #(
  parameter int Width = 10,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/coloring_scc_labeler.sv -----
// Strongly connected component labeler using the colouring method.
// Requests arrive on the in_valid/in_stall channel with op, edge_index,
// edge_from, edge_to and query_vertex; each request gives exactly one
// response on out_valid/out_stall carrying component_label, label_valid
// and component_count.
// A load, a read or an unused op code goes through state S_OUT, where its
// response is registered; no new request is taken until that response has
// been accepted.
// A run clears the assignment flags of the vertices, then repeats
// rounds until every vertex has a label: colour set-up over the vertices,
// forward edge sweeps until no colour changes, a root pass over the
// vertices, and backward edge sweeps until nothing changes. Every step
// goes through the read ports of the vertex memories, which sets the pace.
// The block accepts one request at a time; in_stall is high while a request
// is being worked on or its response is waiting.
// When the receiver stalls, the response is held unchanged and no new
// request is taken. Reset sets vertex_count to 1024, edge_count to 0 and the
// component count to zero, then clears all 1024 words of the vertex memory
// with in_stall high; the edge memories are not cleared.
module coloring_scc_labeler
  import csl_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      op,
  input  logic [11:0]     edge_index,
  input  logic [9:0]      edge_from,
  input  logic [9:0]      edge_to,
  input  logic [9:0]      query_vertex,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [9:0]      component_label,
  output logic            label_valid,
  output logic [10:0]     component_count
);
  state_t state;
  logic [VCW-1:0] vertex_count;
  logic [ECW-1:0] edge_count;
  logic [VCW-1:0] nv;
  logic [ECW-1:0] ne;
  logic [VCW-1:0] vi;
  logic [ECW-1:0] ei;
  logic [10:0] count;
  logic [VCW-1:0] done_cnt;
  logic changed;
  logic [1:0] req_op;
  logic [VW-1:0] req_q;
  logic [VW-1:0] eu, ev;

  logic          es_we;
  logic [EW-1:0] es_addr;
  logic [VW-1:0] es_src, es_dst;
  logic          v_we;
  logic [VW-1:0] v_waddr, v_raddr_a, v_raddr_b;
  vertex_word_t  v_wdata, rd_a, rd_b;
  logic          work_ok;
  logic          fwd_hit, back_hit, root_hit, read_hit;

  assign nv = (vertex_count > VCW'(MaxVertices)) ? VCW'(MaxVertices) : vertex_count;
  assign ne = (edge_count > ECW'(MaxEdges)) ? ECW'(MaxEdges) : edge_count;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign component_count = count;

  csl_ram #(.Width(VW), .Depth(MaxEdges)) u_src (
    .clk(clk), .we(es_we), .waddr(edge_index), .wdata(edge_from),
    .raddr(es_addr), .rdata(es_src));
  csl_ram #(.Width(VW), .Depth(MaxEdges)) u_dst (
    .clk(clk), .we(es_we), .waddr(edge_index), .wdata(edge_to),
    .raddr(es_addr), .rdata(es_dst));
  csl_ram #(.Width(WordW), .Depth(MaxVertices)) u_vtx_a (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr_a), .rdata(rd_a));
  csl_ram #(.Width(WordW), .Depth(MaxVertices)) u_vtx_b (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr_b), .rdata(rd_b));

  assign es_we = in_valid && !in_stall && (op == OpLoad);
  assign es_addr = ei[EW-1:0];
  assign v_raddr_b = es_dst;
  assign work_ok = ({1'b0, eu} < nv) && ({1'b0, ev} < nv);
  assign fwd_hit = work_ok && !rd_a.assigned && !rd_b.assigned &&
                   (rd_a.colour < rd_b.colour);
  assign back_hit = work_ok && rd_b.assigned && !rd_a.assigned &&
                    (rd_a.colour == rd_b.label);
  assign root_hit = !rd_a.assigned && (rd_a.colour == vi[VW-1:0]);
  assign read_hit = (req_op == OpRead) && ({1'b0, req_q} < nv) && rd_a.assigned;

  always_comb begin
    if (state == S_IDLE) begin
      v_raddr_a = query_vertex;
    end else if (state inside {S_FRD, S_BRD}) begin
      v_raddr_a = es_src;
    end else begin
      v_raddr_a = vi[VW-1:0];
    end
  end

  always_comb begin
    v_we = 1'b0;
    v_waddr = vi[VW-1:0];
    v_wdata = '0;
    case (state)
      S_WIPE: begin
        v_we = 1'b1;
      end
      S_CLR: begin
        v_we = (vi != nv);
      end
      S_INITW: begin
        v_we = !rd_a.assigned;
        v_wdata = rd_a;
        v_wdata.colour = vi[VW-1:0];
      end
      S_FEX: begin
        v_we = fwd_hit;
        v_waddr = ev;
        v_wdata = rd_b;
        v_wdata.colour = rd_a.colour;
      end
      S_RROOT: begin
        v_we = root_hit;
        v_wdata = rd_a;
        v_wdata.assigned = 1'b1;
        v_wdata.label = vi[VW-1:0];
      end
      S_BEX: begin
        v_we = back_hit;
        v_waddr = eu;
        v_wdata = rd_a;
        v_wdata.assigned = 1'b1;
        v_wdata.label = rd_b.label;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
      vertex_count <= VCW'(MaxVertices);
      edge_count <= '0;
      count <= '0;
      out_valid <= 1'b0;
      label_valid <= 1'b0;
      component_label <= '0;
      vi <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgVertexCount) begin
          vertex_count <= cfg_data[VCW-1:0];
        end else begin
          edge_count <= cfg_data;
        end
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_WIPE: begin
          if (vi == VCW'(MaxVertices - 1)) begin
            state <= S_IDLE;
          end
          vi <= vi + 1'b1;
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req_op <= op;
            req_q <= query_vertex;
            vi <= '0;
            if (op == OpRun) begin
              count <= '0;
              done_cnt <= '0;
              state <= S_CLR;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_CLR: begin
          if (vi == nv) begin
            state <= S_CHK;
          end else begin
            vi <= vi + 1'b1;
          end
        end
        S_CHK: begin
          if (done_cnt == nv) begin
            state <= S_OUT;
          end else begin
            vi <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          if (vi == nv) begin
            ei <= '0;
            changed <= 1'b0;
            state <= S_FADDR;
          end else begin
            state <= S_INITW;
          end
        end
        S_INITW: begin
          vi <= vi + 1'b1;
          state <= S_INIT;
        end
        S_FADDR: begin
          if (ei == ne) begin
            if (changed) begin
              ei <= '0;
              changed <= 1'b0;
            end else begin
              vi <= '0;
              state <= S_ROOT;
            end
          end else begin
            state <= S_FRD;
          end
        end
        S_FRD: begin
          eu <= es_src;
          ev <= es_dst;
          state <= S_FEX;
        end
        S_FEX: begin
          if (fwd_hit) begin
            changed <= 1'b1;
          end
          ei <= ei + 1'b1;
          state <= S_FADDR;
        end
        S_ROOT: begin
          if (vi == nv) begin
            ei <= '0;
            changed <= 1'b0;
            state <= S_BADDR;
          end else begin
            state <= S_RROOT;
          end
        end
        S_RROOT: begin
          if (root_hit) begin
            count <= count + 1'b1;
            done_cnt <= done_cnt + 1'b1;
          end
          vi <= vi + 1'b1;
          state <= S_ROOT;
        end
        S_BADDR: begin
          if (ei == ne) begin
            if (changed) begin
              ei <= '0;
              changed <= 1'b0;
            end else begin
              state <= S_CHK;
            end
          end else begin
            state <= S_BRD;
          end
        end
        S_BRD: begin
          eu <= es_src;
          ev <= es_dst;
          state <= S_BEX;
        end
        S_BEX: begin
          if (back_hit) begin
            done_cnt <= done_cnt + 1'b1;
            changed <= 1'b1;
          end
          ei <= ei + 1'b1;
          state <= S_BADDR;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          label_valid <= read_hit;
          component_label <= read_hit ? rd_a.label : '0;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ----- hdl/csl_checker.sv -----
module csl_checker
  import csl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        label_valid,
  input logic [9:0]  component_label,
  input logic [10:0] component_count
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(component_label))
    else $error("response changed under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken while response pending");
  a_lab: assert property (@(posedge clk) disable iff (rst)
    out_valid && !label_valid |-> component_label == '0)
    else $error("label without valid");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !in_valid |=> $stable(component_count))
    else $error("count changed without request");
endmodule

bind coloring_scc_labeler csl_checker u_csl_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .label_valid(label_valid),
  .component_label(component_label), .component_count(component_count));

// ----- tb/coloring_scc_labeler_test.sv -----
`timescale 1ns / 100ps

module coloring_scc_labeler_test;
  import csl_pkg::*;

  localparam logic [1:0] OpNone = 2'd3;
  localparam int StallLimit = 2000000;

  typedef struct packed {
    logic [9:0]  label;
    logic        valid;
    logic [10:0] count;
  } label_reply_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic            cfg_index = CfgVertexCount;
  logic [CfgW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [1:0]      op = OpLoad;
  logic [11:0]     edge_index = '0;
  logic [9:0]      edge_from = '0;
  logic [9:0]      edge_to = '0;
  logic [9:0]      query_vertex = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [9:0]      component_label;
  logic            label_valid;
  logic [10:0]     component_count;

  coloring_scc_labeler dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the labeler state.
  logic [9:0]  edge_src [MaxEdges];
  logic [9:0]  edge_dst [MaxEdges];
  logic [9:0]  colour_of [MaxVertices];
  logic [9:0]  root_of [MaxVertices];
  logic        is_labelled [MaxVertices];
  logic [10:0] scc_total;
  logic [10:0] vertices_reg;
  logic [12:0] edges_reg;

  label_reply_t pending_replies[$];
  int  sender_idle = 0;
  int  receiver_idle = 0;
  int  quiet_cycles = 0;
  bit  failed = 1'b0;

  function automatic int live_vertices();
    return (vertices_reg > MaxVertices) ? MaxVertices : int'(vertices_reg);
  endfunction

  function automatic void label_components();
    int nv;
    int ne;
    int left;
    int found;
    int u;
    int v;
    bit changed;
    nv = live_vertices();
    ne = (edges_reg > MaxEdges) ? MaxEdges : int'(edges_reg);
    found = 0;
    for (int i = 0; i < nv; i++) is_labelled[i] = 1'b0;
    left = nv;
    while (left > 0) begin
      for (int i = 0; i < nv; i++)
        if (!is_labelled[i]) colour_of[i] = i[9:0];
      do begin
        changed = 1'b0;
        for (int e = 0; e < ne; e++) begin
          u = edge_src[e];
          v = edge_dst[e];
          if (u < nv && v < nv && !is_labelled[u] && !is_labelled[v] &&
              colour_of[u] < colour_of[v]) begin
            colour_of[v] = colour_of[u];
            changed = 1'b1;
          end
        end
      end while (changed);
      for (int i = 0; i < nv; i++)
        if (!is_labelled[i] && colour_of[i] == i[9:0]) begin
          is_labelled[i] = 1'b1;
          root_of[i] = i[9:0];
          found++;
        end
      do begin
        changed = 1'b0;
        for (int e = 0; e < ne; e++) begin
          u = edge_src[e];
          v = edge_dst[e];
          if (u < nv && v < nv && is_labelled[v] && !is_labelled[u] &&
              colour_of[u] == root_of[v]) begin
            is_labelled[u] = 1'b1;
            root_of[u] = root_of[v];
            changed = 1'b1;
          end
        end
      end while (changed);
      left = 0;
      for (int i = 0; i < nv; i++)
        if (!is_labelled[i]) left++;
    end
    scc_total = found[10:0];
  endfunction

  function automatic label_reply_t predict_reply(logic [1:0] o, logic [11:0] slot,
                                                 logic [9:0] from, logic [9:0] to,
                                                 logic [9:0] q);
    label_reply_t r;
    r = '0;
    if (o == OpLoad) begin
      edge_src[slot] = from;
      edge_dst[slot] = to;
    end else if (o == OpRun) begin
      label_components();
    end else if (o == OpRead) begin
      if (q < live_vertices() && is_labelled[q]) begin
        r.label = root_of[q];
        r.valid = 1'b1;
      end
    end
    r.count = scc_total;
    return r;
  endfunction

  task automatic send_request(logic [1:0] o, logic [11:0] slot, logic [9:0] from,
                              logic [9:0] to, logic [9:0] q);
    if ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    in_valid <= 1'b1;
    op <= o;
    edge_index <= slot;
    edge_from <= from;
    edge_to <= to;
    query_vertex <= q;
    do @(posedge clk); while (in_stall);
    pending_replies.insert(pending_replies.size(), predict_reply(o, slot, from, to, q));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CfgW-1:0];
    @(posedge clk);
    if (idx == CfgVertexCount) vertices_reg = value[10:0];
    else edges_reg = value[12:0];
  endtask

  task automatic configure(int vertices, int edges);
    drain();
    write_register(CfgVertexCount, vertices);
    write_register(CfgEdgeCount, edges);
    cfg_we <= 1'b0;
  endtask

  task automatic test_small_graph();
    send_request(OpRead, 0, 0, 0, 0);
    send_request(OpNone, 12'hfff, 10'h3ff, 10'h3ff, 10'h3ff);
    send_request(OpLoad, 0, 0, 1, 0);
    send_request(OpLoad, 1, 1, 2, 0);
    send_request(OpLoad, 2, 2, 0, 0);
    send_request(OpLoad, 3, 3, 4, 0);
    send_request(OpLoad, 4, 4, 3, 0);
    send_request(OpLoad, 5, 5, 6, 0);
    send_request(OpLoad, 6, 7, 1023, 0);
    send_request(OpLoad, 7, 1023, 1023, 0);
    configure(8, 8);
    send_request(OpRun, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) send_request(OpRead, 0, 0, 0, i[9:0]);
    send_request(OpRead, 0, 0, 0, 10'd1023);
    send_request(OpNone, 0, 0, 0, 0);
  endtask

  task automatic test_register_extremes();
    configure(0, 8);
    send_request(OpRun, 0, 0, 0, 0);
    send_request(OpRead, 0, 0, 0, 0);
    configure(2047, 8);
    send_request(OpRun, 0, 0, 0, 0);
    send_request(OpRead, 0, 0, 0, 10'd1023);
    send_request(OpRead, 0, 0, 0, 10'd2);
    configure(1024, 0);
    send_request(OpRun, 0, 0, 0, 0);
    send_request(OpRead, 0, 0, 0, 10'd512);
    configure(1, 8);
    send_request(OpRun, 0, 0, 0, 0);
    send_request(OpRead, 0, 0, 0, 0);
    send_request(OpRead, 0, 0, 0, 1);
  endtask

  // Fills the low edge slots so that any edge count up to 32 may be used from here on.
  task automatic test_edge_slots();
    configure(4, 0);
    for (int s = 0; s < 32; s++) begin
      if (s < 6)
        send_request(OpLoad, s[11:0], 10'($urandom_range(3)), 10'($urandom_range(3)), 0);
      else
        send_request(OpLoad, s[11:0], 10'($urandom_range(1023, 4)),
                     10'($urandom_range(1023)), 0);
    end
    configure(4, 32);
    send_request(OpRun, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) send_request(OpRead, 0, 0, 0, i[9:0]);
  endtask

  task automatic test_random_traffic(int items);
    int vc;
    int sel;
    logic [9:0] from;
    logic [9:0] to;
    vc = 8;
    for (int n = 0; n < items; n++) begin
      if (n % 40 == 0) begin
        vc = $urandom_range(16, 1);
        configure(vc, $urandom_range(32));
      end
      sel = $urandom_range(99);
      if (sel < 50) begin
        from = ($urandom_range(19) == 0) ? 10'($urandom) : 10'($urandom_range(vc));
        to = ($urandom_range(19) == 0) ? 10'($urandom) : 10'($urandom_range(vc));
        send_request(OpLoad, ($urandom_range(9) == 0) ? 12'($urandom) :
                     12'($urandom_range(31)), from, to, 10'($urandom));
      end else if (sel < 60) begin
        send_request(OpRun, 12'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
      end else if (sel < 95) begin
        send_request(OpRead, 12'($urandom), 10'($urandom), 10'($urandom),
                     ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(vc)));
      end else begin
        send_request(OpNone, 12'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < receiver_idle);
  end

  always @(posedge clk) begin
    label_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: response with no request outstanding: label %0d valid %0d count %0d",
                 $time, component_label, label_valid, component_count);
        failed = 1'b1;
      end else begin
        want = pending_replies.pop_front();
        if (component_label !== want.label) begin
          $display("%0t: component_label expected %0d actual %0d",
                   $time, want.label, component_label);
          failed = 1'b1;
        end
        if (label_valid !== want.valid) begin
          $display("%0t: label_valid expected %0d actual %0d",
                   $time, want.valid, label_valid);
          failed = 1'b1;
        end
        if (component_count !== want.count) begin
          $display("%0t: component_count expected %0d actual %0d",
                   $time, want.count, component_count);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < MaxVertices; i++) is_labelled[i] = 1'b0;
    scc_total = '0;
    vertices_reg = 11'd1024;
    edges_reg = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sender_idle = 9;
    receiver_idle = 76;
    test_small_graph();
    test_register_extremes();
    test_edge_slots();
    test_random_traffic(240);
    sender_idle = 76;
    receiver_idle = 9;
    test_random_traffic(240);
    sender_idle = 0;
    receiver_idle = 0;
    test_random_traffic(250);
    drain();
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/csl_pkg.sv
hdl/csl_ram.sv
hdl/coloring_scc_labeler.sv
hdl/csl_checker.sv
tb/coloring_scc_labeler_test.sv
